// ----- rtl/core/ledfe_pkg.sv -----
// Package: types, codes and tables shared by the LED display frame encoder.
`default_nettype none
package ledfe_pkg;

    typedef enum logic [2:0] {
        OP_NUMBER     = 3'd0,
        OP_COMMAND    = 3'd1,
        OP_CLEAR      = 3'd2,
        OP_TEXT_START = 3'd3,
        OP_TEXT_BYTE  = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [13:0] number;
        logic [7:0]  byte_in;
        logic [3:0]  text_address;
        logic        final_req;
    } item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       frame_end;
        logic       last;
    } beat_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t         kind;
        logic [13:0] value;
        logic [7:0]  data;
        logic        final_req;
    } cmd_t;

    localparam logic [7:0]  ADDR_CMD    = 8'hC0;
    localparam logic [7:0]  DATA_CMD    = 8'h40;
    localparam logic [13:0] NUM_MAX     = 14'd9999;
    localparam logic [3:0]  NUMBER_LAST = 4'd4;
    localparam logic [3:0]  CLEAR_LAST  = 4'd15;

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // decimal weight of the digit sent at a given byte index of a number frame
    function automatic logic [13:0] digit_weight(input logic [3:0] idx);
        logic [13:0] w;
        case (idx)
            4'd1:    w = 14'd1000;
            4'd2:    w = 14'd100;
            4'd3:    w = 14'd10;
            4'd4:    w = 14'd1;
            default: w = 14'd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ledfe_front.sv -----
// Front: holds the digit address register, classifies items and clamps numbers.
`default_nettype none
module ledfe_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    input  wire logic [3:0]       cfg_data,
    input  wire logic             item_valid,
    input  wire ledfe_pkg::item_t item,
    input  wire logic             q_full,
    output logic                  item_stall,
    output logic                  push,
    output ledfe_pkg::cmd_t       push_data
);

    logic [3:0] digit_address_reg;
    logic [3:0] digit_address_next;
    logic       op_ok;

    always_comb
    begin
        digit_address_next = digit_address_reg;
        if (cfg_valid)
        begin
            digit_address_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_address_reg <= 4'd0;
        end
        else
        begin
            digit_address_reg <= digit_address_next;
        end
    end

    assign op_ok      = (item.op == ledfe_pkg::OP_NUMBER) ||
                        (item.op == ledfe_pkg::OP_COMMAND) ||
                        (item.op == ledfe_pkg::OP_CLEAR) ||
                        (item.op == ledfe_pkg::OP_TEXT_START) ||
                        (item.op == ledfe_pkg::OP_TEXT_BYTE);
    assign item_stall = q_full;
    // unused op codes are taken and dropped
    assign push       = item_valid && !q_full && op_ok;

    always_comb
    begin
        push_data.kind      = ledfe_pkg::op_t'(item.op);
        push_data.value     = (item.number > ledfe_pkg::NUM_MAX) ? ledfe_pkg::NUM_MAX
                                                                 : item.number;
        push_data.final_req = item.final_req;
        case (item.op)
            ledfe_pkg::OP_NUMBER:     push_data.data = ledfe_pkg::ADDR_CMD |
                                                       {4'd0, digit_address_reg};
            ledfe_pkg::OP_TEXT_START: push_data.data = ledfe_pkg::ADDR_CMD |
                                                       {4'd0, item.text_address};
            default:                  push_data.data = item.byte_in;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/ledfe_queue.sv -----
// Queue: small FIFO of classified commands between front and back.
`default_nettype none
module ledfe_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ledfe_pkg::cmd_t push_data,
    input  wire logic            pop,
    output ledfe_pkg::cmd_t      pop_data,
    output logic                 full,
    output logic                 empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ledfe_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/ledfe_back.sv -----
// Back: byte sequencer that expands one command into its frame beats.
`default_nettype none
module ledfe_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ledfe_pkg::cmd_t pop_data,
    input  wire logic            q_empty,
    output logic                 pop,
    input  wire logic            beat_stall,
    output logic                 beat_valid,
    output ledfe_pkg::beat_t     beat
);

    ledfe_pkg::cmd_t  cur_reg, cur_next;
    logic             busy_reg, busy_next;
    logic [3:0]       idx_reg, idx_next;
    logic [13:0]      rem_reg, rem_next;
    logic             beat_valid_reg, beat_valid_next;
    ledfe_pkg::beat_t beat_reg, beat_next;

    ledfe_pkg::beat_t gen;
    logic [13:0]      weight;
    logic [13:0]      step;
    logic [13:0]      sub;
    logic [3:0]       digit;
    logic             adv;

    // one decimal digit of the remainder: largest k with k*weight <= rem
    always_comb
    begin
        weight = ledfe_pkg::digit_weight(idx_reg);
        digit  = 4'd0;
        sub    = 14'd0;
        step   = 14'd0;
        for (int k = 1; k <= 9; k++)
        begin
            step = 14'(k) * weight;
            if (rem_reg >= step)
            begin
                digit = 4'(k);
                sub   = step;
            end
        end
    end

    always_comb
    begin
        gen = '0;
        case (cur_reg.kind)
            ledfe_pkg::OP_NUMBER:
            begin
                gen.byte_out  = (idx_reg == 4'd0) ? cur_reg.data
                                                  : ledfe_pkg::seg_code(digit);
                gen.frame_end = (idx_reg == ledfe_pkg::NUMBER_LAST);
                gen.last      = (idx_reg == ledfe_pkg::NUMBER_LAST);
            end
            ledfe_pkg::OP_COMMAND:
            begin
                gen.byte_out  = cur_reg.data;
                gen.frame_end = 1'b1;
                gen.last      = 1'b1;
            end
            ledfe_pkg::OP_CLEAR:
            begin
                gen.byte_out  = (idx_reg == 4'd0) ? ledfe_pkg::DATA_CMD :
                                (idx_reg == 4'd1) ? ledfe_pkg::ADDR_CMD : 8'h00;
                gen.frame_end = (idx_reg == ledfe_pkg::CLEAR_LAST);
                gen.last      = (idx_reg == ledfe_pkg::CLEAR_LAST);
            end
            ledfe_pkg::OP_TEXT_START:
            begin
                gen.byte_out  = cur_reg.data;
                gen.frame_end = cur_reg.final_req;
                gen.last      = 1'b1;
            end
            ledfe_pkg::OP_TEXT_BYTE:
            begin
                gen.byte_out  = (idx_reg == 4'd0) ? cur_reg.data : 8'h00;
                gen.frame_end = (idx_reg != 4'd0) && cur_reg.final_req;
                gen.last      = (idx_reg != 4'd0);
            end
            default:
            begin
                gen.last = 1'b1;
            end
        endcase
    end

    assign adv = !beat_valid_reg || !beat_stall;

    always_comb
    begin
        cur_next        = cur_reg;
        busy_next       = busy_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        beat_next       = beat_reg;
        beat_valid_next = beat_valid_reg && beat_stall;
        pop             = 1'b0;
        if (busy_reg)
        begin
            if (adv)
            begin
                beat_next       = gen;
                beat_valid_next = 1'b1;
                idx_next        = idx_reg + 1'b1;
                rem_next        = rem_reg - sub;
                if (gen.last)
                begin
                    busy_next = !q_empty;
                    pop       = !q_empty;
                    cur_next  = pop_data;
                    idx_next  = 4'd0;
                    rem_next  = pop_data.value;
                end
            end
        end
        else if (!q_empty)
        begin
            pop       = 1'b1;
            busy_next = 1'b1;
            cur_next  = pop_data;
            idx_next  = 4'd0;
            rem_next  = pop_data.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            idx_reg        <= 4'd0;
            beat_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            idx_reg        <= idx_next;
            beat_valid_reg <= beat_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        rem_reg  <= rem_next;
        beat_reg <= beat_next;
    end

    assign beat_valid = beat_valid_reg;
    assign beat       = beat_reg;

endmodule
`default_nettype wire

// ----- rtl/core/led_display_frame_encoder.sv -----
// Top level: LED display frame encoder, front / queue / back.
//
//   channel  dir  handshake              beat
//   item     in   item_valid/item_stall  item_t (op, number, byte_in, text_address, final_req)
//   beat     out  beat_valid/beat_stall  beat_t (byte_out, frame_end, last)
//   cfg      in   cfg_valid/cfg_ready    digit_address (4 bits)
//
// The back sequencer emits one byte per cycle while beat_stall is low; bytes
// per item: number 5, command 1, clear 16, text start 1, text byte 2.
// Unused op codes are accepted and produce nothing.
// From idle, the sequencer loads a command before it emits its first byte.
// Reset clears digit_address, the queue and the output valid flag.
// item_stall is high only while the command queue is full.
`default_nettype none
module led_display_frame_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [3:0]       cfg_data,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire ledfe_pkg::item_t item,
    output logic                  beat_valid,
    input  wire logic             beat_stall,
    output ledfe_pkg::beat_t      beat
);

    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    ledfe_pkg::cmd_t push_data;
    ledfe_pkg::cmd_t pop_data;

    assign cfg_ready = 1'b1;

    ledfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .q_full     (q_full),
        .item_stall (item_stall),
        .push       (push),
        .push_data  (push_data)
    );

    ledfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    ledfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_data   (pop_data),
        .q_empty    (q_empty),
        .pop        (pop),
        .beat_stall (beat_stall),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty command queue");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!q_full && !item_stall))
        else $error("push into full command queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !q_empty)
        else $error("pushed command missing from queue");

endmodule
`default_nettype wire

// ----- tb/sv/led_display_frame_encoder_test.sv -----
// Testbench for the LED display frame encoder: directed and random requests checked against a local model.
`timescale 1ns / 1ps
module led_display_frame_encoder_test;

    localparam int CLK_HALF_NS      = 10;
    localparam int RESET_CYCLES     = 4;
    localparam int SETTLE_CYCLES    = 40;
    localparam int LIMIT_CYCLES     = 1000000;
    localparam int CLEAR_ZERO_BYTES = 14;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              cfg_valid  = 1'b0;
    logic [3:0]        cfg_data   = 4'd0;
    logic              item_valid = 1'b0;
    ledfe_pkg::item_t  item       = '0;
    logic              beat_stall = 1'b0;
    logic              cfg_ready;
    logic              item_stall;
    logic              beat_valid;
    ledfe_pkg::beat_t  beat;

    ledfe_pkg::item_t  requests_pending[$];
    ledfe_pkg::beat_t  frame_bytes_due[$];
    ledfe_pkg::beat_t  want_beat;
    logic [3:0]  digit_addr_shadow = 4'd0;
    logic        item_taken = 1'b0;
    logic        steady_send = 1'b0;
    logic        steady_recv = 1'b0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          error_count = 0;
    int          bytes_checked = 0;
    int          items_taken = 0;
    int          op_seen[8];
    int          addr_writes = 0;

    led_display_frame_encoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .beat_valid (beat_valid),
        .beat_stall (beat_stall),
        .beat       (beat)
    );

    initial
    begin
        forever
        begin
            #(CLK_HALF_NS) clk = ~clk;
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Timeout with %0d bytes still due", frame_bytes_due.size());
        $display("Verification failed");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        error_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [7:0] segments_for_digit(input int d);
        case (d)
            0: return 8'b0011_1111;
            1: return 8'b0000_0110;
            2: return 8'b0101_1011;
            3: return 8'b0100_1111;
            4: return 8'b0110_0110;
            5: return 8'b0110_1101;
            6: return 8'b0111_1101;
            7: return 8'b0000_0111;
            8: return 8'b0111_1111;
            default: return 8'b0110_1111;
        endcase
    endfunction

    function automatic ledfe_pkg::beat_t frame_byte(input logic [7:0] b, input logic fe);
        ledfe_pkg::beat_t x;
        x.byte_out  = b;
        x.frame_end = fe;
        x.last      = 1'b0;
        return x;
    endfunction

    // bytes the driver chip must see for one request
    function automatic void encode_request(input ledfe_pkg::item_t req);
        ledfe_pkg::beat_t frame[$];
        int    value;
        int    weight;
        case (req.op)
            ledfe_pkg::OP_NUMBER:
            begin
                value = (req.number > ledfe_pkg::NUM_MAX) ? int'(ledfe_pkg::NUM_MAX)
                                                          : int'(req.number);
                frame.push_back(frame_byte(ledfe_pkg::ADDR_CMD | {4'h0, digit_addr_shadow},
                                           1'b0));
                for (weight = 1000; weight > 0; weight = weight / 10)
                    frame.push_back(frame_byte(segments_for_digit((value / weight) % 10),
                                               weight == 1));
            end
            ledfe_pkg::OP_COMMAND:
                frame.push_back(frame_byte(req.byte_in, 1'b1));
            ledfe_pkg::OP_CLEAR:
            begin
                frame.push_back(frame_byte(ledfe_pkg::DATA_CMD, 1'b0));
                frame.push_back(frame_byte(ledfe_pkg::ADDR_CMD, 1'b0));
                for (int i = 0; i < CLEAR_ZERO_BYTES; i++)
                    frame.push_back(frame_byte(8'h00, i == CLEAR_ZERO_BYTES - 1));
            end
            ledfe_pkg::OP_TEXT_START:
                frame.push_back(frame_byte(ledfe_pkg::ADDR_CMD | {4'h0, req.text_address},
                                           req.final_req));
            ledfe_pkg::OP_TEXT_BYTE:
            begin
                frame.push_back(frame_byte(req.byte_in, 1'b0));
                frame.push_back(frame_byte(8'h00, req.final_req));
            end
            default: ;
        endcase
        if (frame.size() > 0)
            frame[frame.size() - 1].last = 1'b1;
        foreach (frame[i])
            frame_bytes_due.push_back(frame[i]);
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (item_valid && !item_taken)
        begin
            item_valid <= 1'b1;
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            item_valid <= 1'b0;
        end
        else if (requests_pending.size() > 0)
        begin
            item       <= requests_pending.pop_front();
            item_valid <= 1'b1;
            send_gap = steady_send ? 0 : pick_gap();
        end
        else
        begin
            item_valid <= 1'b0;
        end
    end

    // output backpressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            beat_stall <= 1'b1;
        end
        else
        begin
            beat_stall <= 1'b0;
            stall_left = steady_recv ? 0 : pick_gap();
        end
    end

    // monitor: predict on accepted requests, check accepted bytes
    always @(posedge clk)
    begin
        item_taken <= item_valid && !item_stall;
        if (rst_n && item_valid && !item_stall)
        begin
            items_taken++;
            op_seen[item.op]++;
            encode_request(item);
        end
        if (rst_n && beat_valid && !beat_stall)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected byte %02h fe=%b last=%b",
                                        beat.byte_out, beat.frame_end, beat.last));
            end
            else
            begin
                want_beat = frame_bytes_due.pop_front();
                bytes_checked++;
                if (beat.byte_out !== want_beat.byte_out)
                    flag_mismatch($sformatf("byte_out %02h, want %02h",
                                            beat.byte_out, want_beat.byte_out));
                if (beat.frame_end !== want_beat.frame_end)
                    flag_mismatch($sformatf("frame_end %b, want %b (byte %02h)",
                                            beat.frame_end, want_beat.frame_end,
                                            want_beat.byte_out));
                if (beat.last !== want_beat.last)
                    flag_mismatch($sformatf("last %b, want %b (byte %02h)",
                                            beat.last, want_beat.last,
                                            want_beat.byte_out));
            end
        end
    end

    function automatic ledfe_pkg::item_t make_request(input logic [2:0] op, input int num,
                                                      input int data, input int addr,
                                                      input logic fin);
        ledfe_pkg::item_t r;
        r.op           = op;
        r.number       = num[13:0];
        r.byte_in      = data[7:0];
        r.text_address = addr[3:0];
        r.final_req    = fin;
        return r;
    endfunction

    function automatic ledfe_pkg::item_t random_request(input logic [2:0] op);
        int num;
        num = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 9999)
                                           : $urandom_range(0, 16383);
        return make_request(op, num, $urandom_range(0, 255), $urandom_range(0, 15),
                            $urandom_range(0, 1));
    endfunction

    task automatic wait_drained();
        while (requests_pending.size() != 0 || item_valid || frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_digit_address(input logic [3:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        digit_addr_shadow = value;
        addr_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_directed();
        requests_pending.push_back(make_request(ledfe_pkg::OP_NUMBER, 0, 0, 0, 1'b0));
        requests_pending.push_back(make_request(ledfe_pkg::OP_NUMBER, 9999, 255, 15, 1'b1));
        requests_pending.push_back(make_request(ledfe_pkg::OP_NUMBER, 10000, 0, 0, 1'b0));
        requests_pending.push_back(make_request(ledfe_pkg::OP_NUMBER, 16383, 255, 15, 1'b0));
        requests_pending.push_back(make_request(ledfe_pkg::OP_NUMBER, 1234, 0, 0, 1'b1));
        requests_pending.push_back(make_request(ledfe_pkg::OP_NUMBER, 5678, 0, 0, 1'b0));
        requests_pending.push_back(make_request(ledfe_pkg::OP_NUMBER, 9087, 0, 0, 1'b0));
        requests_pending.push_back(make_request(ledfe_pkg::OP_COMMAND, 0, 8'h00, 0, 1'b0));
        requests_pending.push_back(make_request(ledfe_pkg::OP_COMMAND, 16383, 8'hFF, 15,
                                                1'b1));
        requests_pending.push_back(make_request(ledfe_pkg::OP_CLEAR, 0, 0, 0, 1'b0));
        requests_pending.push_back(make_request(ledfe_pkg::OP_CLEAR, 16383, 255, 15, 1'b1));
        requests_pending.push_back(make_request(ledfe_pkg::OP_TEXT_START, 0, 0, 0, 1'b0));
        requests_pending.push_back(make_request(ledfe_pkg::OP_TEXT_BYTE, 0, 8'hFF, 0, 1'b0));
        requests_pending.push_back(make_request(ledfe_pkg::OP_TEXT_BYTE, 0, 8'h00, 0, 1'b1));
        requests_pending.push_back(make_request(ledfe_pkg::OP_TEXT_START, 16383, 255, 15,
                                                1'b1));
        requests_pending.push_back(make_request(ledfe_pkg::OP_TEXT_START, 0, 0, 9, 1'b0));
        requests_pending.push_back(make_request(ledfe_pkg::OP_TEXT_BYTE, 16383, 8'hA5, 15,
                                                1'b0));
        requests_pending.push_back(make_request(ledfe_pkg::OP_TEXT_BYTE, 0, 8'h5A, 0, 1'b1));
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            requests_pending.push_back(make_request(op[2:0], 16383, 255, 15, 1'b1));
        requests_pending.push_back(make_request(ledfe_pkg::OP_COMMAND, 0, 8'h8F, 0, 1'b0));
    endtask

    // mostly well-formed text frames and single-frame requests, some noise
    task automatic queue_random(input int count);
        int made;
        int r;
        int nbytes;
        ledfe_pkg::item_t req;
        made = 0;
        while (made < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                req = random_request(ledfe_pkg::OP_TEXT_START);
                req.final_req = ($urandom_range(0, 9) == 0);
                requests_pending.push_back(req);
                nbytes = $urandom_range(1, 4);
                for (int i = 0; i < nbytes; i++)
                begin
                    req = random_request(ledfe_pkg::OP_TEXT_BYTE);
                    req.final_req = (i == nbytes - 1);
                    requests_pending.push_back(req);
                end
                made += 1 + nbytes;
            end
            else
            begin
                if (r < 55)
                    req = random_request(ledfe_pkg::OP_NUMBER);
                else if (r < 70)
                    req = random_request(ledfe_pkg::OP_COMMAND);
                else if (r < 75)
                    req = random_request(ledfe_pkg::OP_CLEAR);
                else if (r < 85)
                    req = random_request(ledfe_pkg::OP_TEXT_BYTE);
                else if (r < 92)
                    req = random_request(ledfe_pkg::OP_TEXT_START);
                else
                    req = random_request(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
                requests_pending.push_back(req);
                if (req.op < OP_SPARE_LO)
                    made++;
            end
            if ($urandom_range(0, 39) == 0)
            begin
                // queue no more requests until the encoder has drained
                wait_drained();
                steady_send = ($urandom_range(0, 3) == 0);
                steady_recv = ($urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset value of the digit address first
        queue_directed();
        wait_drained();

        write_digit_address(4'd15);
        queue_random(95);
        wait_drained();

        write_digit_address(4'd0);
        queue_random(90);
        wait_drained();

        write_digit_address(4'($urandom_range(1, 14)));
        queue_random(90);
        wait_drained();

        steady_send = 1'b1;
        steady_recv = 1'b1;
        write_digit_address(4'd8);
        queue_random(90);
        wait_drained();

        steady_send = 1'b0;
        steady_recv = 1'b0;
        write_digit_address(4'($urandom_range(0, 15)));
        queue_random(90);
        wait_drained();

        if (frame_bytes_due.size() != 0)
            flag_mismatch($sformatf("%0d bytes never arrived", frame_bytes_due.size()));

        $display("Covered %0d requests (number %0d, command %0d, clear %0d,",
                 items_taken, op_seen[ledfe_pkg::OP_NUMBER], op_seen[ledfe_pkg::OP_COMMAND],
                 op_seen[ledfe_pkg::OP_CLEAR]);
        $display("  text start %0d, text byte %0d); checked %0d frame bytes across",
                 op_seen[ledfe_pkg::OP_TEXT_START], op_seen[ledfe_pkg::OP_TEXT_BYTE],
                 bytes_checked);
        $display("  %0d digit address settings, %0d errors", addr_writes + 1, error_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ledfe_pkg.sv
rtl/core/ledfe_front.sv
rtl/core/ledfe_queue.sv
rtl/core/ledfe_back.sv
rtl/core/led_display_frame_encoder.sv
tb/sv/led_display_frame_encoder_test.sv
